// ----- sv/coo_pkg.sv -----
// shared constants and codes for the coordinate to compressed row converter
package coo_pkg;

  // port field widths
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned COL_W   = 17;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned PTR_W   = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFGA_W  = 2;

  // stored entry: row kept as wide as a column so mirrored rows survive
  localparam int unsigned EROW_W  = COL_W;
  localparam int unsigned ENT_W   = EROW_W + COL_W + VAL_W;

  // bit pattern of 1.0 in double precision
  localparam logic [VAL_W-1:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

  // item modes
  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_CONVERT = 2'd1,
    MODE_RD_PTR  = 2'd2,
    MODE_RD_ENT  = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [CFGA_W-1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_SYMMETRIC = 2'd1;
  localparam logic [CFGA_W-1:0] CFG_PATTERN   = 2'd2;
  localparam logic [CFGA_W-1:0] CFG_CAPACITY  = 2'd3;

endpackage

// ----- sv/coo_ram.sv -----
// generic single write port ram with one registered read port
module coo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/coo_to_csr_converter.sv -----
// coordinate to compressed sparse row converter top level
//
//  channel   ports                                     handshake
//  --------  ----------------------------------------  -------------------------
//  command   mode_i row_i col_i value_i index_i        start_i high, busy_o low
//  result    status_o row_ptr_o col_out_o value_out_o  done_o strobe, one cycle
//  config    cfg_idx_i cfg_wdata_i                     cfg_we_i
//
// load: one entry ram store, a second in S_LOAD_MIR for a mirrored entry.
// read row pointer: row pointer ram read. read sorted entry: order ram then
// entry ram, both registered reads. convert: insertion sort over the entry
// ram, then clear of row pointers 0 to rows, per-entry row counts and the
// prefix sum. reset clears the sequencer state, counts and done flag and sets
// the config registers to defaults; other registers and the rams are not reset.
// done_o is high for one cycle per result; result outputs hold until the next.
module coo_to_csr_converter #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned COL_BITS    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [coo_pkg::CFGA_W-1:0]  cfg_idx_i,
  input  logic [coo_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        start_i,
  input  logic [1:0]                  mode_i,
  input  logic [coo_pkg::ROW_W-1:0]   row_i,
  input  logic [coo_pkg::COL_W-1:0]   col_i,
  input  logic [coo_pkg::VAL_W-1:0]   value_i,
  input  logic [coo_pkg::IDX_W-1:0]   index_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [coo_pkg::PTR_W-1:0]   row_ptr_o,
  output logic [COL_BITS-1:0]         col_out_o,
  output logic [coo_pkg::VAL_W-1:0]   value_out_o
);
  import coo_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PW = $clog2(MAX_ROWS + 1);
  localparam int unsigned RW = $clog2(MAX_ROWS + 2);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_LOAD_MIR = 16'h0002,
    S_SRT_RD   = 16'h0004,
    S_SRT_KEY  = 16'h0008,
    S_SRT_ORD  = 16'h0010,
    S_SRT_CMP  = 16'h0020,
    S_SRT_PUT  = 16'h0040,
    S_CLR      = 16'h0080,
    S_CNT_RD   = 16'h0100,
    S_CNT_ROW  = 16'h0200,
    S_CNT_WR   = 16'h0400,
    S_PRE_RD   = 16'h0800,
    S_PRE_WR   = 16'h1000,
    S_RD_PTR   = 16'h2000,
    S_RD_ORD   = 16'h4000,
    S_RD_ENT   = 16'h8000
  } state_e;

  // configuration registers
  logic [ROW_W-1:0] num_rows_q;
  logic             symmetric_q;
  logic             pattern_q;
  logic [CFG_W-1:0] capacity_q;

  // control state
  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       sorted_len_q, sorted_len_d;
  logic [RW-1:0]       ptr_len_q, ptr_len_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       j_q, j_d;
  logic [RW-1:0]       k_q, k_d;
  logic [CW-1:0]       acc_q, acc_d;
  logic [PW-1:0]       r_q, r_d;
  logic [IW-1:0]       p_q, p_d;
  logic [EROW_W-1:0]   cur_row_q, cur_row_d;
  logic [COL_W-1:0]    cur_col_q, cur_col_d;
  logic [EROW_W-1:0]   mir_row_q, mir_row_d;
  logic [COL_W-1:0]    mir_col_q, mir_col_d;
  logic [VAL_W-1:0]    mir_val_q, mir_val_d;

  // result registers
  logic                done_q, done_d;
  logic [1:0]          status_q, status_d;
  logic [PTR_W-1:0]    row_ptr_q, row_ptr_d;
  logic [COL_BITS-1:0] col_out_q, col_out_d;
  logic [VAL_W-1:0]    value_out_q, value_out_d;

  // ram ports
  logic             ent_we;
  logic [IW-1:0]    ent_waddr, ent_raddr;
  logic [ENT_W-1:0] ent_wdata, ent_rdata;
  logic             ord_we;
  logic [IW-1:0]    ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic             rp_we;
  logic [PW-1:0]    rp_waddr, rp_raddr;
  logic [CW-1:0]    rp_wdata, rp_rdata;

  // helpers
  logic [EROW_W-1:0] ent_row;
  logic [COL_W-1:0]  ent_col;
  logic [VAL_W-1:0]  ent_val;
  logic [RW-1:0]     rows;
  logic              has_room;
  logic [VAL_W-1:0]  ld_val;
  logic [CW-1:0]     jm1;
  logic [31:0]       col_m1;

  // finish of an item
  logic                fin;
  logic [1:0]          fin_status;
  logic [PTR_W-1:0]    fin_rp;
  logic [COL_BITS-1:0] fin_col;
  logic [VAL_W-1:0]    fin_val;

  assign ent_row = ent_rdata[ENT_W-1 -: EROW_W];
  assign ent_col = ent_rdata[VAL_W +: COL_W];
  assign ent_val = ent_rdata[VAL_W-1:0];
  assign rows    = (32'(num_rows_q) < 32'(MAX_ROWS)) ? RW'(num_rows_q) : RW'(MAX_ROWS);
  assign has_room = (32'(count_q) < 32'(capacity_q)) && (32'(count_q) < 32'(MAX_ENTRIES));
  assign ld_val  = pattern_q ? ONE_BITS : value_i;
  assign jm1     = j_q - CW'(1);
  assign col_m1  = 32'(ent_col) - 32'd1;

  coo_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  coo_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  coo_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS + 1)) u_rp_ram (
    .clk_i   (clk_i),
    .we_i    (rp_we),
    .waddr_i (rp_waddr),
    .wdata_i (rp_wdata),
    .raddr_i (rp_raddr),
    .rdata_o (rp_rdata)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sorted_len_d = sorted_len_q;
    ptr_len_d    = ptr_len_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    acc_d        = acc_q;
    r_d          = r_q;
    p_d          = p_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    mir_row_d    = mir_row_q;
    mir_col_d    = mir_col_q;
    mir_val_d    = mir_val_q;
    ent_we       = 1'b0;
    ent_waddr    = count_q[IW-1:0];
    ent_wdata    = '0;
    ent_raddr    = i_q[IW-1:0];
    ord_we       = 1'b0;
    ord_waddr    = j_q[IW-1:0];
    ord_wdata    = '0;
    ord_raddr    = '0;
    rp_we        = 1'b0;
    rp_waddr     = k_q[PW-1:0];
    rp_wdata     = '0;
    rp_raddr     = k_q[PW-1:0];
    fin          = 1'b0;
    fin_status   = ST_OK;
    fin_rp       = '0;
    fin_col      = '0;
    fin_val      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            MODE_LOAD: begin
              if (has_room) begin
                ent_we    = 1'b1;
                ent_wdata = {EROW_W'(row_i), col_i, ld_val};
                count_d   = count_q + CW'(1);
                if (symmetric_q && (COL_W'(row_i) != col_i)) begin
                  mir_row_d = col_i;
                  mir_col_d = COL_W'(row_i);
                  mir_val_d = ld_val;
                  state_d   = S_LOAD_MIR;
                end else begin
                  fin = 1'b1;
                end
              end else begin
                fin        = 1'b1;
                fin_status = ST_OVERFLOW;
              end
            end
            MODE_CONVERT: begin
              i_d     = '0;
              state_d = S_SRT_RD;
            end
            MODE_RD_PTR: begin
              if (32'(index_i) < 32'(ptr_len_q)) begin
                rp_raddr = PW'(index_i);
                state_d  = S_RD_PTR;
              end else begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end
            end
            MODE_RD_ENT: begin
              if (32'(index_i) < 32'(sorted_len_q)) begin
                ord_raddr = IW'(index_i);
                state_d   = S_RD_ORD;
              end else begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // second store of a symmetric load
      S_LOAD_MIR: begin
        fin = 1'b1;
        if (has_room) begin
          ent_we    = 1'b1;
          ent_wdata = {mir_row_q, mir_col_q, mir_val_q};
          count_d   = count_q + CW'(1);
        end else begin
          fin_status = ST_OVERFLOW;
        end
        state_d = S_IDLE;
      end
      // insertion sort: fetch key of entry i
      S_SRT_RD: begin
        if (i_q == count_q) begin
          k_d     = '0;
          state_d = S_CLR;
        end else begin
          ent_raddr = i_q[IW-1:0];
          state_d   = S_SRT_KEY;
        end
      end
      S_SRT_KEY: begin
        cur_row_d = ent_row;
        cur_col_d = ent_col;
        j_d       = i_q;
        if (i_q == '0) begin
          state_d = S_SRT_PUT;
        end else begin
          ord_raddr = IW'(i_q - CW'(1));
          state_d   = S_SRT_ORD;
        end
      end
      S_SRT_ORD: begin
        p_d       = ord_rdata;
        ent_raddr = ord_rdata;
        state_d   = S_SRT_CMP;
      end
      // shift the larger key up one slot
      S_SRT_CMP: begin
        if ({ent_row, ent_col} > {cur_row_q, cur_col_q}) begin
          ord_we    = 1'b1;
          ord_waddr = j_q[IW-1:0];
          ord_wdata = p_q;
          j_d       = jm1;
          if (jm1 != '0) begin
            ord_raddr = IW'(jm1 - CW'(1));
            state_d   = S_SRT_ORD;
          end else begin
            state_d = S_SRT_PUT;
          end
        end else begin
          state_d = S_SRT_PUT;
        end
      end
      S_SRT_PUT: begin
        ord_we    = 1'b1;
        ord_waddr = j_q[IW-1:0];
        ord_wdata = i_q[IW-1:0];
        i_d       = i_q + CW'(1);
        state_d   = S_SRT_RD;
      end
      // clear row pointers 0 to rows
      S_CLR: begin
        rp_we    = 1'b1;
        rp_waddr = k_q[PW-1:0];
        if (k_q == rows) begin
          i_d     = '0;
          state_d = S_CNT_RD;
        end else begin
          k_d = k_q + RW'(1);
        end
      end
      // per-row counts
      S_CNT_RD: begin
        if (i_q == count_q) begin
          k_d     = RW'(1);
          acc_d   = '0;
          state_d = S_PRE_RD;
        end else begin
          ent_raddr = i_q[IW-1:0];
          state_d   = S_CNT_ROW;
        end
      end
      S_CNT_ROW: begin
        if ((ent_row != '0) && (32'(ent_row) <= 32'(rows))) begin
          rp_raddr = PW'(ent_row);
          r_d      = PW'(ent_row);
          state_d  = S_CNT_WR;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_CNT_RD;
        end
      end
      S_CNT_WR: begin
        rp_we    = 1'b1;
        rp_waddr = r_q;
        rp_wdata = rp_rdata + CW'(1);
        i_d      = i_q + CW'(1);
        state_d  = S_CNT_RD;
      end
      // prefix sum
      S_PRE_RD: begin
        if (k_q > rows) begin
          sorted_len_d = count_q;
          ptr_len_d    = rows + RW'(1);
          fin          = 1'b1;
          state_d      = S_IDLE;
        end else begin
          rp_raddr = k_q[PW-1:0];
          state_d  = S_PRE_WR;
        end
      end
      S_PRE_WR: begin
        rp_we    = 1'b1;
        rp_waddr = k_q[PW-1:0];
        rp_wdata = acc_q + rp_rdata;
        acc_d    = acc_q + rp_rdata;
        k_d      = k_q + RW'(1);
        state_d  = S_PRE_RD;
      end
      // reads
      S_RD_PTR: begin
        fin     = 1'b1;
        fin_rp  = PTR_W'(rp_rdata);
        state_d = S_IDLE;
      end
      S_RD_ORD: begin
        ent_raddr = ord_rdata;
        state_d   = S_RD_ENT;
      end
      S_RD_ENT: begin
        fin     = 1'b1;
        fin_col = col_m1[COL_BITS-1:0];
        fin_val = ent_val;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result word
  always_comb begin
    done_d      = fin;
    status_d    = status_q;
    row_ptr_d   = row_ptr_q;
    col_out_d   = col_out_q;
    value_out_d = value_out_q;
    if (fin) begin
      status_d    = fin_status;
      row_ptr_d   = fin_rp;
      col_out_d   = fin_col;
      value_out_d = fin_val;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      sorted_len_q <= '0;
      ptr_len_q    <= '0;
      done_q       <= 1'b0;
      num_rows_q   <= ROW_W'(256);
      symmetric_q  <= 1'b0;
      pattern_q    <= 1'b0;
      capacity_q   <= CFG_W'(1024);
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      sorted_len_q <= sorted_len_d;
      ptr_len_q    <= ptr_len_d;
      done_q       <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NUM_ROWS:  num_rows_q  <= cfg_wdata_i[ROW_W-1:0];
          CFG_SYMMETRIC: symmetric_q <= cfg_wdata_i[0];
          CFG_PATTERN:   pattern_q   <= cfg_wdata_i[0];
          CFG_CAPACITY:  capacity_q  <= cfg_wdata_i;
          default:       capacity_q  <= capacity_q;
        endcase
      end
    end
  end

  // payload and loop registers
  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    acc_q       <= acc_d;
    r_q         <= r_d;
    p_q         <= p_d;
    cur_row_q   <= cur_row_d;
    cur_col_q   <= cur_col_d;
    mir_row_q   <= mir_row_d;
    mir_col_q   <= mir_col_d;
    mir_val_q   <= mir_val_d;
    status_q    <= status_d;
    row_ptr_q   <= row_ptr_d;
    col_out_q   <= col_out_d;
    value_out_q <= value_out_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign row_ptr_o   = row_ptr_q;
  assign col_out_o   = col_out_q;
  assign value_out_o = value_out_q;

endmodule
